// ----- rtl/lbca_pkg.sv -----
// Shared constants for the linked block chain allocator.
`timescale 1ns / 1ps

package lbca_pkg;

	localparam int DEF_MAX_BLOCKS  = 256;
	localparam int DEF_MAX_INODES  = 32;
	localparam int DEF_BLOCK_BYTES = 512;

	localparam int LINK_W    = 10;
	localparam int INODE_W   = 5;
	localparam int SIZE_W    = 24;
	localparam int STATUS_W  = 2;
	localparam int BLKCFG_W  = 9;
	localparam int INOCFG_W  = 6;
	localparam int S_DATA_W  = 32;
	localparam int M_DATA_W  = 8;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [LINK_W-1:0] LINK_FREE = 10'h3FF;
	localparam logic [LINK_W-1:0] LINK_END  = 10'h3FE;

	localparam logic KIND_ALLOC  = 1'b0;
	localparam logic KIND_RESIZE = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_INODE  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NO_BLOCK  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_BAD_INODE = 2'd3;

	localparam logic REG_BLOCKS = 1'b0;
	localparam logic REG_INODES = 1'b1;

	localparam logic [BLKCFG_W-1:0] BLOCKS_RESET = 9'd256;
	localparam logic [INOCFG_W-1:0] INODES_RESET = 6'd32;

endpackage

// ----- rtl/linked_block_chain_allocator_core.sv -----
// Top level of the linked block chain allocator: link table, inode table and sequencer.
`timescale 1ns / 1ps

// Usage:
//   Requests enter on the s_axis channel, one word per request. tuser carries the
//   kind (allocate or resize), tdata the target inode and the file size in bytes.
//   One result word per request leaves on m_axis: inode index and status.
//   Two registers on the APB port limit how many blocks and inodes are searched;
//   write them only while no request is in flight.
//   A request passes in order through: inode scan for the lowest free index
//   (allocate only), block scan (allocate only), start of the chain, a walk
//   over the chain blocks, growth by free blocks (blocks in use are skipped),
//   freeing of the blocks past the new end, and a finish. The single-port
//   link memory has a registered read, and the free scans test one entry a
//   cycle. Free scans resume where the last one in a request stopped, so
//   growth scans the block table at most once per request. One request is
//   processed at a time.
//   Reset marks every block and inode free at once; no clearing pass is needed.
//   A result waits in the output register while m_axis_tready is low; the next
//   request is still taken, and the sequencer holds before its own result.
module linked_block_chain_allocator_core #(
	parameter int MAX_BLOCKS  = lbca_pkg::DEF_MAX_BLOCKS,
	parameter int MAX_INODES  = lbca_pkg::DEF_MAX_INODES,
	parameter int BLOCK_BYTES = lbca_pkg::DEF_BLOCK_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// target_inode [4:0], file_size [28:5], zero [31:29]
	input  logic [lbca_pkg::S_DATA_W-1:0] s_axis_tdata,
	// kind [0]
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// inode_index [4:0], status [6:5], zero [7]
	output logic [lbca_pkg::M_DATA_W-1:0] m_axis_tdata,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lbca_pkg::PADDR_W-1:0]  paddr,
	input  logic [lbca_pkg::PDATA_W-1:0]  pwdata,
	output logic [lbca_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import lbca_pkg::*;

	localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int IW = (MAX_INODES > 1) ? $clog2(MAX_INODES) : 1;
	localparam int CW = SIZE_W + 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ISCAN = 4'd1;
	localparam logic [3:0] S_BSCAN = 4'd2;
	localparam logic [3:0] S_FB    = 4'd3;
	localparam logic [3:0] S_LEND  = 4'd4;
	localparam logic [3:0] S_WRD   = 4'd5;
	localparam logic [3:0] S_WCHK  = 4'd6;
	localparam logic [3:0] S_GSCAN = 4'd7;
	localparam logic [3:0] S_GLINK = 4'd8;
	localparam logic [3:0] S_TRD   = 4'd9;
	localparam logic [3:0] S_TCHK  = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;
	localparam logic [3:0] S_RES   = 4'd12;

	logic [3:0]          state_q;
	logic [BLKCFG_W-1:0] blocks_q;
	logic [INOCFG_W-1:0] inodes_q;

	logic [LINK_W-1:0]   link_mem [MAX_BLOCKS];
	logic [BW-1:0]       ifb_mem [MAX_INODES];
	logic [MAX_BLOCKS-1:0] free_q;
	logic [MAX_INODES-1:0] alloc_q;

	logic [LINK_W-1:0]   link_rdata_q;
	logic                link_rfree_q;
	logic [BW-1:0]       ifb_rdata_q;

	logic [SIZE_W-1:0]   size_q;
	logic [CW-1:0]       covered_q;
	logic [BW-1:0]       cur_q;
	logic [BW-1:0]       ext_q;
	logic [LINK_W-1:0]   walk_q;
	logic [LINK_W-1:0]   bptr_q;
	logic [LINK_W-1:0]   guard_q;
	logic [8:0]          iptr_q;
	logic [INODE_W-1:0]  idx_q;
	logic [STATUS_W-1:0] status_q;

	logic                s_acc;
	logic                cfg_wr;
	logic                out_free;
	logic [INODE_W-1:0]  tgt;
	logic [8:0]          tgt9;
	logic                tgt_ok;
	logic                iptr_in;
	logic                bptr_in;
	logic                bptr_free;
	logic [LINK_W-1:0]   link_val;
	logic                link_is_blk;
	logic                walk_is_blk;
	logic                walk_go;
	logic                covered_done;
	logic                link_re;
	logic [BW-1:0]       link_raddr;
	logic                link_we;
	logic [LINK_W-1:0]   link_wdata;

	assign pready        = 1'b1;
	assign cfg_wr        = psel && penable && pwrite && pready;
	assign prdata        = (paddr[2] == REG_INODES) ? PDATA_W'(inodes_q) : PDATA_W'(blocks_q);
	assign s_axis_tready = (state_q == S_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	assign tgt     = s_axis_tdata[INODE_W-1:0];
	assign tgt9    = 9'(tgt);
	assign tgt_ok  = (tgt9 < 9'(inodes_q)) && (tgt9 < 9'(MAX_INODES)) && alloc_q[tgt9[IW-1:0]];
	assign iptr_in = (iptr_q < 9'(inodes_q)) && (iptr_q < 9'(MAX_INODES));
	assign bptr_in = (bptr_q < LINK_W'(blocks_q)) && (bptr_q < LINK_W'(MAX_BLOCKS));
	assign bptr_free = free_q[bptr_q[BW-1:0]];

	assign link_val     = link_rfree_q ? LINK_FREE : link_rdata_q;
	assign link_is_blk  = link_val < LINK_W'(MAX_BLOCKS);
	assign walk_is_blk  = walk_q < LINK_W'(MAX_BLOCKS);
	assign walk_go      = walk_is_blk && (guard_q != LINK_W'(MAX_BLOCKS));
	assign covered_done = covered_q >= CW'(size_q);

	assign link_re    = (state_q == S_WRD) || ((state_q == S_TRD) && walk_go);
	assign link_raddr = (state_q == S_WRD) ? cur_q : walk_q[BW-1:0];
	assign link_we    = (state_q == S_GLINK) || (state_q == S_LEND) || (state_q == S_FIN);
	assign link_wdata = (state_q == S_GLINK) ? LINK_W'(ext_q) : LINK_END;

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[cur_q] <= link_wdata;
		end
		if (link_re) begin
			link_rdata_q <= link_mem[link_raddr];
			link_rfree_q <= free_q[link_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_BSCAN) && bptr_in && bptr_free) begin
			ifb_mem[iptr_q[IW-1:0]] <= bptr_q[BW-1:0];
		end
		if (s_acc) begin
			ifb_rdata_q <= ifb_mem[tgt9[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_q <= BLOCKS_RESET;
			inodes_q <= INODES_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_INODES) begin
				inodes_q <= pwdata[INOCFG_W-1:0];
			end else begin
				blocks_q <= pwdata[BLKCFG_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_RES) && out_free) begin
			m_axis_tdata <= {1'b0, status_q, idx_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			free_q        <= '1;
			alloc_q       <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && (state_q != S_RES)) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						size_q    <= s_axis_tdata[INODE_W +: SIZE_W];
						covered_q <= CW'(BLOCK_BYTES);
						bptr_q    <= '0;
						iptr_q    <= '0;
						guard_q   <= '0;
						status_q  <= STAT_OK;
						if (s_axis_tuser == KIND_ALLOC) begin
							idx_q   <= '0;
							state_q <= S_ISCAN;
						end else if (!tgt_ok) begin
							idx_q    <= tgt;
							status_q <= STAT_BAD_INODE;
							state_q  <= S_RES;
						end else begin
							idx_q   <= tgt;
							state_q <= S_FB;
						end
					end
				end
				S_ISCAN: begin
					if (!iptr_in) begin
						status_q <= STAT_NO_INODE;
						state_q  <= S_RES;
					end else if (!alloc_q[iptr_q[IW-1:0]]) begin
						idx_q   <= iptr_q[INODE_W-1:0];
						state_q <= S_BSCAN;
					end else begin
						iptr_q <= iptr_q + 9'd1;
					end
				end
				S_BSCAN: begin
					if (!bptr_in) begin
						status_q <= STAT_NO_BLOCK;
						state_q  <= S_RES;
					end else if (bptr_free) begin
						alloc_q[iptr_q[IW-1:0]] <= 1'b1;
						free_q[bptr_q[BW-1:0]]  <= 1'b0;
						cur_q   <= bptr_q[BW-1:0];
						bptr_q  <= bptr_q + LINK_W'(1);
						state_q <= S_LEND;
					end else begin
						bptr_q <= bptr_q + LINK_W'(1);
					end
				end
				S_FB: begin
					cur_q   <= ifb_rdata_q;
					state_q <= S_WRD;
				end
				S_LEND: begin
					state_q <= S_WRD;
				end
				S_WRD: begin
					state_q <= S_WCHK;
				end
				S_WCHK: begin
					if (covered_done || (link_val != LINK_END && !link_is_blk)) begin
						walk_q  <= link_val;
						state_q <= S_TRD;
					end else if (link_val == LINK_END) begin
						state_q <= S_GSCAN;
					end else begin
						cur_q     <= link_val[BW-1:0];
						covered_q <= covered_q + CW'(BLOCK_BYTES);
						state_q   <= S_WRD;
					end
				end
				S_GSCAN: begin
					if (!bptr_in) begin
						status_q <= STAT_NO_BLOCK;
						state_q  <= S_FIN;
					end else if (bptr_free) begin
						ext_q   <= bptr_q[BW-1:0];
						bptr_q  <= bptr_q + LINK_W'(1);
						state_q <= S_GLINK;
					end else begin
						bptr_q <= bptr_q + LINK_W'(1);
					end
				end
				S_GLINK: begin
					free_q[ext_q] <= 1'b0;
					cur_q         <= ext_q;
					covered_q     <= covered_q + CW'(BLOCK_BYTES);
					state_q       <= S_LEND;
				end
				S_TRD: begin
					state_q <= walk_go ? S_TCHK : S_FIN;
				end
				S_TCHK: begin
					free_q[walk_q[BW-1:0]] <= 1'b1;
					walk_q  <= link_val;
					guard_q <= guard_q + LINK_W'(1);
					state_q <= S_TRD;
				end
				S_FIN: begin
					free_q[cur_q] <= 1'b0;
					state_q       <= S_RES;
				end
				S_RES: begin
					if (out_free) begin
						m_axis_tvalid <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> state_q != S_IDLE)
		else $error("accepted word did not start a request");

	a_result_from_res: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == S_RES))
		else $error("result word raised outside result state");

	a_walk_cur_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WRD |-> !free_q[cur_q])
		else $error("chain walk reached a free block");

	a_ext_is_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GLINK |-> free_q[ext_q])
		else $error("growth took a block in use");

endmodule
